/* design/assert_macros.svh */
// Assertion macros shared by the checker of the sentence framer.
// No dependencies; expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NSF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nsf: implication check failed");

// Next-cycle implication, checked outside reset.
`define NSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nsf: next-cycle check failed");

`endif

/* design/nsf_pkg.sv */
// Shared types and constants of the NMEA sentence framer.
// No dependencies.
`default_nettype none

package nsf_pkg;

    localparam int BUF_DEPTH_DEF = 256;
    localparam int TYPE_COUNT    = 6;
    // Command queue depth between front and back; power of two.
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_ENABLE = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    localparam logic [2:0] END_UNKNOWN = 3'd6;
    localparam logic [2:0] END_NONE    = 3'd7;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // GGA, GLL, GSA, GSV, RMC, VTG
    localparam logic [7:0] TYPE_CODES [TYPE_COUNT][3] = '{
        '{8'h47, 8'h47, 8'h41},
        '{8'h47, 8'h4C, 8'h4C},
        '{8'h47, 8'h53, 8'h41},
        '{8'h47, 8'h53, 8'h56},
        '{8'h52, 8'h4D, 8'h43},
        '{8'h56, 8'h54, 8'h47}
    };

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
        logic [2:0] read_type;
        logic [7:0] read_index;
        logic [5:0] enable_mask;
        logic       is_dollar;
        logic       is_newline;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

endpackage

`default_nettype wire

/* design/nmea_sentence_framer_core.sv */
// NMEA sentence framer: capture of received bytes, type match, per-type sentence store.
// Top level; instantiates nsf_front and nsf_back, depends on nsf_pkg.
//
// Input channel (in_valid/in_ready) carries one command word: a received byte, a read of
// a stored byte, a write of the per-type enables, or a clear of flags and lengths. Every
// word gives exactly one result word on the output channel (out_valid/out_ready).
// The front end queues up to two words, so the sender keeps going while a result waits.
// The back end takes a byte, enable or clear word from the queue and loads its result
// register; a read also passes through the registered store RAM read. A newline that
// closes a recognized, enabled sentence starts a copy into the store, each copied byte
// a capture RAM read, then a store write, ending at the captured end or at a CR; the back
// end takes no new word until the copy is done, so that copy loop sets the worst-case rate.
// Otherwise the back end retires one word per cycle while the receiver takes results,
// but a read holds it in the read-wait state before it takes the next word.
// Reset clears capture state, flags and stored lengths and sets all write enables; RAM
// contents are left as they are and are never read before being written.
// When out_ready is low the result is held, the back end takes no new word, and the queue
// fills and then drops in_ready.
`default_nettype none

module nmea_sentence_framer_core
    import nsf_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] kind,
    input  wire logic [7:0] rx_byte,
    input  wire logic [2:0] read_type,
    input  wire logic [7:0] read_index,
    input  wire logic [5:0] enable_mask,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      read_byte,
    output logic [8:0]      stored_length,
    output logic [5:0]      got_mask,
    output logic            sentence_ready,
    output logic            in_sentence,
    output logic [2:0]      ended_type
);

    q_head_t head;
    logic    pop;

    // Accept and classify words; hold them in the short queue.
    nsf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .rx_byte     (rx_byte),
        .read_type   (read_type),
        .read_index  (read_index),
        .enable_mask (enable_mask),
        .head        (head),
        .pop         (pop)
    );

    // Execute one word at a time and drive the result register.
    nsf_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_byte      (read_byte),
        .stored_length  (stored_length),
        .got_mask       (got_mask),
        .sentence_ready (sentence_ready),
        .in_sentence    (in_sentence),
        .ended_type     (ended_type)
    );

endmodule

`default_nettype wire

/* design/nsf_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module nsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* design/nsf_front.sv */
// Front end of the sentence framer: input handshake, classification, command queue.
// Depends on nsf_pkg.
`default_nettype none

module nsf_front
    import nsf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] kind,
    input  wire logic [7:0] rx_byte,
    input  wire logic [2:0] read_type,
    input  wire logic [7:0] read_index,
    input  wire logic [5:0] enable_mask,
    output q_head_t         head,
    input  wire logic       pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    cmd_t             cmd_in;
    logic             push;

    // Classify the incoming word.
    always_comb
    begin
        cmd_in.kind        = kind;
        cmd_in.rx_byte     = rx_byte;
        cmd_in.read_type   = read_type;
        cmd_in.read_index  = read_index;
        cmd_in.enable_mask = enable_mask;
        cmd_in.is_dollar   = (rx_byte == CH_DOLLAR);
        cmd_in.is_newline  = (rx_byte == CH_LF);
    end

    assign in_ready = (fill_reg != CNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign head.valid = (fill_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

/* design/nsf_back.sv */
// Back end of the sentence framer: capture, sentence match, store copy, reads, result register.
// Depends on nsf_pkg and nsf_ram.
`default_nettype none

module nsf_back
    import nsf_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  q_head_t         head,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      read_byte,
    output logic [8:0]      stored_length,
    output logic [5:0]      got_mask,
    output logic            sentence_ready,
    output logic            in_sentence,
    output logic [2:0]      ended_type
);

    localparam int IDX_W       = $clog2(BUF_DEPTH);
    localparam int CNT_W       = $clog2(BUF_DEPTH + 1);
    localparam int POS_W       = CNT_W + 1;
    localparam int STORE_DEPTH = TYPE_COUNT * BUF_DEPTH;
    localparam int SAW         = $clog2(STORE_DEPTH);
    localparam int CMP_W       = (CNT_W > 8) ? CNT_W : 8;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_COPY_RD = 2'd1;
    localparam logic [1:0] ST_COPY_WR = 2'd2;
    localparam logic [1:0] ST_RD_WAIT = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             capturing_reg, capturing_next;
    logic             ready_reg, ready_next;
    logic [5:0]       got_reg, got_next;
    logic [5:0]       wen_reg, wen_next;
    logic [CNT_W-1:0] len_reg [TYPE_COUNT];
    logic [CNT_W-1:0] len_next [TYPE_COUNT];
    logic [7:0]       tbyte_reg [3];
    logic [7:0]       tbyte_next [3];
    logic [2:0]       t_reg, t_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [2:0]       rd_type_reg, rd_type_next;
    logic [7:0]       rd_idx_reg, rd_idx_next;

    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic [8:0]       out_len_reg;
    logic [5:0]       out_got_reg;
    logic             out_ready_flag_reg;
    logic             out_insent_reg;
    logic [2:0]       out_ended_reg;

    logic             load;
    logic [7:0]       ld_byte;
    logic [8:0]       ld_len;
    logic [2:0]       ld_ended;
    logic             out_free;

    logic             cap_we;
    logic [IDX_W-1:0] cap_waddr;
    logic [IDX_W-1:0] cap_raddr;
    logic [7:0]       cap_rdata;
    logic             st_we;
    logic [SAW-1:0]   st_waddr;
    logic [SAW-1:0]   st_raddr;
    logic [7:0]       st_rdata;

    logic [2:0]       match_t;

    nsf_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_capture_ram (
        .clk   (clk),
        .we    (cap_we),
        .waddr (cap_waddr),
        .wdata (head.cmd.rx_byte),
        .raddr (cap_raddr),
        .rdata (cap_rdata)
    );

    nsf_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (cap_rdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign out_free = !out_valid_reg || out_ready;

    // Sentence type from the shadowed bytes 3..5; short captures never match.
    always_comb
    begin
        match_t = END_UNKNOWN;
        if (count_reg >= CNT_W'(6))
        begin
            for (int i = TYPE_COUNT - 1; i >= 0; i--)
            begin
                if (tbyte_reg[0] == TYPE_CODES[i][0] &&
                    tbyte_reg[1] == TYPE_CODES[i][1] &&
                    tbyte_reg[2] == TYPE_CODES[i][2])
                begin
                    match_t = 3'(i);
                end
            end
        end
    end

    always_comb
    begin
        logic [CNT_W-1:0] wr_cnt;
        logic             wr_cap;
        logic [POS_W-1:0] pos;
        logic [CMP_W-1:0] sel_len;

        state_next     = state_reg;
        count_next     = count_reg;
        capturing_next = capturing_reg;
        ready_next     = ready_reg;
        got_next       = got_reg;
        wen_next       = wen_reg;
        len_next       = len_reg;
        tbyte_next     = tbyte_reg;
        t_next         = t_reg;
        n_next         = n_reg;
        rd_type_next   = rd_type_reg;
        rd_idx_next    = rd_idx_reg;

        pop       = 1'b0;
        load      = 1'b0;
        ld_byte   = '0;
        ld_len    = '0;
        ld_ended  = END_NONE;
        cap_we    = 1'b0;
        cap_waddr = '0;
        cap_raddr = '0;
        st_we     = 1'b0;
        st_waddr  = SAW'(t_reg) * SAW'(BUF_DEPTH) + SAW'(n_reg);
        st_raddr  = SAW'(head.cmd.read_type) * SAW'(BUF_DEPTH) + SAW'(head.cmd.read_index);

        wr_cnt  = head.cmd.is_dollar ? '0 : count_reg;
        wr_cap  = head.cmd.is_dollar || capturing_reg;
        pos     = POS_W'(n_reg) + POS_W'(3);
        sel_len = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid && out_free)
                begin
                    pop = 1'b1;
                    unique case (head.cmd.kind)
                        KIND_BYTE:
                        begin
                            if (head.cmd.is_dollar)
                            begin
                                capturing_next = 1'b1;
                                count_next     = '0;
                                ready_next     = 1'b0;
                            end
                            if (head.cmd.is_newline && capturing_reg)
                            begin
                                // End of sentence: flag it, then copy if enabled.
                                capturing_next = 1'b0;
                                ready_next     = 1'b1;
                                if (match_t != END_UNKNOWN)
                                begin
                                    got_next = got_reg | (6'd1 << match_t);
                                end
                                if (match_t != END_UNKNOWN && wen_reg[match_t])
                                begin
                                    t_next     = match_t;
                                    n_next     = '0;
                                    state_next = ST_COPY_RD;
                                end
                                else
                                begin
                                    load     = 1'b1;
                                    ld_ended = match_t;
                                end
                            end
                            else
                            begin
                                // Append while there is room; drop once full.
                                if (wr_cap && wr_cnt < CNT_W'(BUF_DEPTH))
                                begin
                                    cap_we     = 1'b1;
                                    cap_waddr  = wr_cnt[IDX_W-1:0];
                                    count_next = wr_cnt + CNT_W'(1);
                                    for (int k = 0; k < 3; k++)
                                    begin
                                        if (wr_cnt == CNT_W'(3 + k))
                                        begin
                                            tbyte_next[k] = head.cmd.rx_byte;
                                        end
                                    end
                                end
                                load = 1'b1;
                            end
                        end
                        KIND_READ:
                        begin
                            rd_type_next = head.cmd.read_type;
                            rd_idx_next  = head.cmd.read_index;
                            state_next   = ST_RD_WAIT;
                        end
                        KIND_ENABLE:
                        begin
                            wen_next = head.cmd.enable_mask;
                            load     = 1'b1;
                        end
                        KIND_CLEAR:
                        begin
                            got_next = '0;
                            for (int i = 0; i < TYPE_COUNT; i++)
                            begin
                                len_next[i] = '0;
                            end
                            load = 1'b1;
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            ST_COPY_RD:
            begin
                if (pos < POS_W'(count_reg) && pos < POS_W'(BUF_DEPTH))
                begin
                    cap_raddr  = pos[IDX_W-1:0];
                    state_next = ST_COPY_WR;
                end
                else
                begin
                    len_next[t_reg] = n_reg;
                    load            = 1'b1;
                    ld_ended        = t_reg;
                    state_next      = ST_IDLE;
                end
            end
            ST_COPY_WR:
            begin
                if (cap_rdata != CH_CR)
                begin
                    st_we      = 1'b1;
                    n_next     = n_reg + CNT_W'(1);
                    state_next = ST_COPY_RD;
                end
                else
                begin
                    len_next[t_reg] = n_reg;
                    load            = 1'b1;
                    ld_ended        = t_reg;
                    state_next      = ST_IDLE;
                end
            end
            ST_RD_WAIT:
            begin
                if (rd_type_reg < 3'(TYPE_COUNT))
                begin
                    sel_len = CMP_W'(len_reg[rd_type_reg]);
                    ld_len  = 9'(len_reg[rd_type_reg]);
                    if (CMP_W'(rd_idx_reg) < sel_len)
                    begin
                        ld_byte = st_rdata;
                    end
                end
                load       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            capturing_reg <= 1'b0;
            ready_reg     <= 1'b0;
            got_reg       <= '0;
            wen_reg       <= '1;
            for (int i = 0; i < TYPE_COUNT; i++)
            begin
                len_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            capturing_reg <= capturing_next;
            ready_reg     <= ready_next;
            got_reg       <= got_next;
            wen_reg       <= wen_next;
            len_reg       <= len_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tbyte_reg   <= tbyte_next;
        t_reg       <= t_next;
        n_reg       <= n_next;
        rd_type_reg <= rd_type_next;
        rd_idx_reg  <= rd_idx_next;
        if (load)
        begin
            out_byte_reg       <= ld_byte;
            out_len_reg        <= ld_len;
            out_got_reg        <= got_next;
            out_ready_flag_reg <= ready_next;
            out_insent_reg     <= capturing_next;
            out_ended_reg      <= ld_ended;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_byte      = out_byte_reg;
    assign stored_length  = out_len_reg;
    assign got_mask       = out_got_reg;
    assign sentence_ready = out_ready_flag_reg;
    assign in_sentence    = out_insent_reg;
    assign ended_type     = out_ended_reg;

endmodule

`default_nettype wire

/* design/nsf_checker.sv */
// Port-level checks of the sentence framer, bound to the top level.
// Depends on assert_macros.svh, nsf_pkg and nmea_sentence_framer_core.
`default_nettype none
`include "assert_macros.svh"

module nsf_checker
    import nsf_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] read_byte,
    input wire logic [8:0] stored_length,
    input wire logic [5:0] got_mask,
    input wire logic       sentence_ready,
    input wire logic       in_sentence,
    input wire logic [2:0] ended_type
);

    logic [27:0] out_word;

    assign out_word = {read_byte, stored_length, got_mask, sentence_ready, in_sentence,
                       ended_type};

    // A sentence end closes capture and raises the ready flag.
    `NSF_ASSERT_IMPL(a_end_closes, out_valid && ended_type != END_NONE, !in_sentence && sentence_ready)

    // A recognized end leaves its got flag set.
    `NSF_ASSERT_IMPL(a_end_sets_got, out_valid && ended_type < END_UNKNOWN, got_mask[ended_type])

    // A nonzero read byte comes only from inside a stored sentence.
    `NSF_ASSERT_IMPL(a_byte_in_len, out_valid && read_byte != 8'd0, stored_length != 9'd0)

    // A stalled result holds.
    `NSF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

endmodule

bind nmea_sentence_framer_core nsf_checker u_nsf_checker (.*);

`default_nettype wire

/* verif/tb_nmea_sentence_framer_core.sv */
// Self-checking testbench for nmea_sentence_framer_core: directed and random words, scored
// against a built-in predictor of capture, type match, per-type store and host commands.
// Depends on nsf_pkg and the framer RTL only.
`default_nettype none

module tb_nmea_sentence_framer_core;
    import nsf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          BUF_DEPTH    = BUF_DEPTH_DEF;
    localparam int unsigned TOTAL_WORDS  = 1930;
    localparam int unsigned CYCLE_LIMIT  = 5_000_000;
    // Cover the longest store copy plus a margin, so a stray late word is caught.
    localparam int unsigned DRAIN_CYCLES = 2 * BUF_DEPTH + 40;
    localparam int unsigned MAX_REPORTS  = 100;

    // Sentence types in store order.
    typedef enum int {TYPE_GGA, TYPE_GLL, TYPE_GSA, TYPE_GSV, TYPE_RMC, TYPE_VTG} nmea_type_t;

    typedef struct packed {
        logic [7:0] rd_byte;
        logic [8:0] length;
        logic [5:0] got;
        logic       ready;
        logic       active;
        logic [2:0] ended;
    } framer_result_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [1:0] kind        = KIND_BYTE;
    logic [7:0] rx_byte     = '0;
    logic [2:0] read_type   = '0;
    logic [7:0] read_index  = '0;
    logic [5:0] enable_mask = '0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [7:0] read_byte;
    logic [8:0] stored_length;
    logic [5:0] got_mask;
    logic       sentence_ready;
    logic       in_sentence;
    logic [2:0] ended_type;

    // Predictor state, starting from the reset values of the framer.
    logic [7:0]  cap_bytes [BUF_DEPTH];
    int unsigned cap_len    = 0;
    bit          capture_on = 1'b0;
    logic [7:0]  type_store [TYPE_COUNT][BUF_DEPTH];
    int unsigned type_len [TYPE_COUNT] = '{default: 0};
    logic [5:0]  write_en   = 6'h3F;
    logic [5:0]  got_bits   = '0;
    bit          ended_flag = 1'b0;

    framer_result_t framer_outputs_due [$];

    int unsigned words_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;
    int unsigned stall_left   = 0;
    // Set to run a stretch with no gaps on either side.
    bit          no_idle      = 1'b0;

    nmea_sentence_framer_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .rx_byte        (rx_byte),
        .read_type      (read_type),
        .read_index     (read_index),
        .enable_mask    (enable_mask),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_byte      (read_byte),
        .stored_length  (stored_length),
        .got_mask       (got_mask),
        .sentence_ready (sentence_ready),
        .in_sentence    (in_sentence),
        .ended_type     (ended_type)
    );

    always #10 clk = ~clk;

    // Bound the run; a hang anywhere ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_nmea_sentence_framer_core failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------
    // Helpers
    // ---------------------------------------------------------------------------------

    function automatic logic [23:0] type_code(input int t);
        case (t)
            TYPE_GGA: return "GGA";
            TYPE_GLL: return "GLL";
            TYPE_GSA: return "GSA";
            TYPE_GSV: return "GSV";
            TYPE_RMC: return "RMC";
            TYPE_VTG: return "VTG";
            default:  return '0;
        endcase
    endfunction

    function automatic logic [7:0] rand_byte(input int unsigned lo, input int unsigned hi);
        rand_byte = 8'($urandom_range(hi, lo));
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned idle_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Field text: digits, commas, periods, letters, asterisks, and the odd raw byte (CR included, never $ or LF).
    function automatic logic [7:0] body_char();
        int unsigned pick;
        logic [7:0]  c;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return rand_byte("0", "9");
        if (pick < 60)
            return ",";
        if (pick < 70)
            return ".";
        if (pick < 90)
            return rand_byte("A", "Z");
        if (pick < 93)
            return "*";
        c = rand_byte(0, 255);
        while (c == CH_DOLLAR || c == CH_LF)
            c = rand_byte(0, 255);
        return c;
    endfunction

    // ---------------------------------------------------------------------------------
    // Predictor: advance the framer by one accepted word and queue the word it returns.
    // ---------------------------------------------------------------------------------
    function automatic void advance_framer(input logic [1:0] k, input logic [7:0] rx,
                                           input logic [2:0] rt, input logic [7:0] ri,
                                           input logic [5:0] mask);
        framer_result_t res;
        int unsigned    n;
        logic [2:0]     found;
        res       = '0;
        res.ended = END_NONE;
        case (k)
            KIND_BYTE:
            begin
                // A dollar restarts capture from byte 0, even mid-sentence.
                if (rx == CH_DOLLAR)
                begin
                    capture_on = 1'b1;
                    cap_len    = 0;
                    ended_flag = 1'b0;
                end
                if (rx == CH_LF && capture_on)
                begin
                    // Too few bytes captured to hold a type: report as unrecognized.
                    found = END_UNKNOWN;
                    if (cap_len >= 6)
                        for (int t = 0; t < TYPE_COUNT; t++)
                            if ({cap_bytes[3], cap_bytes[4], cap_bytes[5]} == type_code(t))
                                found = 3'(t);
                    capture_on = 1'b0;
                    if (found != END_UNKNOWN)
                    begin
                        // Copy from the type field up to the first CR or the captured end.
                        if (write_en[found])
                        begin
                            n = 0;
                            while (3 + n < cap_len && 3 + n < BUF_DEPTH &&
                                   cap_bytes[3 + n] != CH_CR)
                            begin
                                type_store[found][n] = cap_bytes[3 + n];
                                n++;
                            end
                            type_len[found] = n;
                        end
                        got_bits[found] = 1'b1;
                    end
                    ended_flag = 1'b1;
                    res.ended  = found;
                end
                // Drop bytes once the buffer is full; capture stays on.
                if (capture_on && cap_len < BUF_DEPTH)
                begin
                    cap_bytes[cap_len] = rx;
                    cap_len++;
                end
            end
            KIND_READ:
            begin
                if (rt < TYPE_COUNT)
                begin
                    res.length = 9'(type_len[rt]);
                    if (ri < type_len[rt])
                        res.rd_byte = type_store[rt][ri];
                end
            end
            KIND_ENABLE:
                write_en = mask;
            default:
            begin
                // Clear leaves sentence_ready alone.
                got_bits = '0;
                foreach (type_len[t])
                    type_len[t] = 0;
            end
        endcase
        res.got    = got_bits;
        res.ready  = ended_flag;
        res.active = capture_on;
        framer_outputs_due.push_back(res);
    endfunction

    // ---------------------------------------------------------------------------------
    // Input side: one word per call, with a random gap before it.
    // ---------------------------------------------------------------------------------
    task automatic send_word(input logic [1:0] k, input logic [7:0] rx, input logic [2:0] rt,
                             input logic [7:0] ri, input logic [5:0] mask);
        int unsigned idle;
        idle = no_idle ? 0 : idle_gap();
        if (idle > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (idle - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        kind        <= k;
        rx_byte     <= rx;
        read_type   <= rt;
        read_index  <= ri;
        enable_mask <= mask;
        // Hold the word until the framer takes it.
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        advance_framer(k, rx, rt, ri, mask);
        words_sent++;
    endtask

    // Unused fields carry random values; the framer must ignore them.
    task automatic send_byte(input logic [7:0] b);
        send_word(KIND_BYTE, b, 3'(rand_byte(0, 7)), rand_byte(0, 255),
                  6'(rand_byte(0, 63)));
    endtask

    task automatic send_read(input int unsigned t, input int unsigned idx);
        send_word(KIND_READ, rand_byte(0, 255), 3'(t), 8'(idx), 6'(rand_byte(0, 63)));
    endtask

    task automatic send_enable(input logic [5:0] mask);
        send_word(KIND_ENABLE, rand_byte(0, 255), 3'(rand_byte(0, 7)), rand_byte(0, 255),
                  mask);
    endtask

    task automatic send_clear();
        send_word(KIND_CLEAR, rand_byte(0, 255), 3'(rand_byte(0, 7)), rand_byte(0, 255),
                  6'(rand_byte(0, 63)));
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Read a stored byte, mostly inside the stored text, sometimes anywhere or a bad type.
    task automatic random_read();
        int unsigned t;
        int unsigned idx;
        if ($urandom_range(0, 9) < 9)
            t = $urandom_range(0, TYPE_COUNT - 1);
        else
            t = $urandom_range(TYPE_COUNT, 7);
        if (t < TYPE_COUNT && type_len[t] > 0 && $urandom_range(0, 3) != 0)
            idx = $urandom_range(0, type_len[t] - 1);
        else
            idx = $urandom_range(0, 255);
        send_read(t, idx);
    endtask

    // One sentence: mostly well formed, sometimes without CR, trailing junk, left open,
    // or cut short before the type field is complete.
    task automatic send_sentence();
        logic [7:0]  text [$];
        logic [23:0] code;
        int unsigned body_len;
        int unsigned ending;
        int unsigned keep;
        text.push_back(CH_DOLLAR);
        if ($urandom_range(0, 9) < 8)
        begin
            text.push_back("G");
            text.push_back("P");
        end
        else
        begin
            text.push_back(rand_byte("A", "Z"));
            text.push_back(rand_byte("A", "Z"));
        end
        if ($urandom_range(0, 99) < 85)
            code = type_code($urandom_range(0, TYPE_COUNT - 1));
        else
            code = {rand_byte("A", "Z"), rand_byte("A", "Z"), rand_byte("A", "Z")};
        text.push_back(code[23:16]);
        text.push_back(code[15:8]);
        text.push_back(code[7:0]);
        body_len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 40) : $urandom_range(41, 120);
        repeat (body_len) text.push_back(body_char());
        ending = $urandom_range(0, 99);
        keep   = (ending >= 96) ? $urandom_range(1, 5) : text.size();
        for (int i = 0; i < keep; i++)
        begin
            // Interleave the odd host read with capture.
            if (i > 0 && $urandom_range(0, 99) < 3)
                random_read();
            send_byte(text[i]);
        end
        if (ending < 80)
        begin
            send_byte(CH_CR);
            send_byte(CH_LF);
        end
        else if (ending < 87)
            send_byte(CH_LF);
        else if (ending < 92)
        begin
            send_byte(CH_CR);
            repeat ($urandom_range(1, 4)) send_byte(body_char());
            send_byte(CH_LF);
        end
        else if (ending >= 96)
            send_byte(CH_LF);
    endtask

    // ---------------------------------------------------------------------------------
    // Output side: random stalls, then score every result word.
    // ---------------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0 && !no_idle)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready  <= 1'b1;
            stall_left = 0;
            if (!no_idle && $urandom_range(0, 99) < 20)
                stall_left = idle_gap() + 1;
        end
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("MISMATCH result %0d: %s got %0d, expected %0d",
                     results_seen, what, got, want);
    endtask

    always @(posedge clk)
    begin : check_results
        framer_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (framer_outputs_due.size() == 0)
                report_mismatch("result word with none due, ended_type", 32'(ended_type),
                                32'(END_NONE));
            else
            begin
                want = framer_outputs_due.pop_front();
                if (read_byte !== want.rd_byte)
                    report_mismatch("read_byte", 32'(read_byte), 32'(want.rd_byte));
                if (stored_length !== want.length)
                    report_mismatch("stored_length", 32'(stored_length), 32'(want.length));
                if (got_mask !== want.got)
                    report_mismatch("got_mask", 32'(got_mask), 32'(want.got));
                if (sentence_ready !== want.ready)
                    report_mismatch("sentence_ready", 32'(sentence_ready), 32'(want.ready));
                if (in_sentence !== want.active)
                    report_mismatch("in_sentence", 32'(in_sentence), 32'(want.active));
                if (ended_type !== want.ended)
                    report_mismatch("ended_type", 32'(ended_type), 32'(want.ended));
            end
            results_seen++;
        end
    end

    // ---------------------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------------------

    // Host commands on empty stores: reads of every kind of type, enable extremes, clear.
    task automatic test_host_commands();
        send_read(TYPE_GGA, 0);
        send_read(7, 255);
        send_read(6, 0);
        send_enable(6'h00);
        send_enable(6'h3F);
        send_clear();
    endtask

    // Ignored bytes outside capture, a stored sentence, short sentence, restart on dollar,
    // recognized sentence with its write disabled, and clear after a store.
    task automatic test_special_sentences();
        send_byte(CH_LF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_text("$GPGGA,9");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_read(TYPE_GGA, 4);
        send_read(TYPE_GGA, 5);
        send_enable(6'h00);
        send_text("$A");
        send_byte(CH_LF);
        send_text("$G$GPVTG");
        send_byte(CH_LF);
        send_enable(6'h3F);
        send_clear();
        send_read(TYPE_GGA, 0);
    endtask

    // Sentences that fill or overrun the capture buffer: exactly full, CR dropped past the end,
    // and CR well inside a long sentence. Read around the top of the store.
    task automatic test_buffer_full();
        int unsigned total;
        int unsigned cr_at;
        int unsigned t;
        logic [23:0] code;
        send_enable(6'h3F);
        for (int round = 0; round < 3; round++)
        begin
            t    = $urandom_range(0, TYPE_COUNT - 1);
            code = type_code(t);
            total = (round == 0) ? BUF_DEPTH : BUF_DEPTH + $urandom_range(1, 60);
            case (round)
                0:       cr_at = total;
                1:       cr_at = total - 1;
                default: cr_at = $urandom_range(100, BUF_DEPTH - 10);
            endcase
            send_text("$GP");
            send_byte(code[23:16]);
            send_byte(code[15:8]);
            send_byte(code[7:0]);
            for (int i = 6; i < total; i++)
                send_byte((i == cr_at) ? CH_CR : body_char());
            send_byte(CH_LF);
            send_read(t, BUF_DEPTH - 4);
            send_read(t, BUF_DEPTH - 3);
            send_read(t, 255);
            send_read(t, 0);
        end
    endtask

    // Random sentences mixed with line noise and host commands, with stretches that run without gaps.
    task automatic test_random_traffic();
        while (words_sent < TOTAL_WORDS)
        begin
            no_idle = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 99) < 20)
                repeat ($urandom_range(1, 4)) send_byte(rand_byte(0, 255));
            send_sentence();
            repeat ($urandom_range(0, 3)) random_read();
            if ($urandom_range(0, 99) < 10)
                send_enable(($urandom_range(0, 9) < 6) ? 6'h3F : 6'(rand_byte(0, 63)));
            if ($urandom_range(0, 99) < 3)
                send_clear();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin : run_tests
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_host_commands();
        test_special_sentences();
        test_buffer_full();
        test_random_traffic();

        @(negedge clk);
        in_valid <= 1'b0;
        // Drain: wait for every due result, then watch for stray words.
        while (framer_outputs_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb_nmea_sentence_framer_core passed");
        else
            $display("tb_nmea_sentence_framer_core failed");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+design
design/nsf_pkg.sv
design/nsf_ram.sv
design/nsf_front.sv
design/nsf_back.sv
design/nmea_sentence_framer_core.sv
design/nsf_checker.sv
verif/tb_nmea_sentence_framer_core.sv
